// ===== hdl/adhi_pkg.sv =====
// Shared types and constants for the ALU delay hazard inserter.
// No dependencies; every other file imports this package.

package adhi_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SLOT_DIST_W = 4;
    localparam int unsigned CODE_W      = 4;
    localparam int unsigned NUM_SLOTS   = 2;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_VALU  = 2'd1,
        CLS_TRANS = 2'd2,
        CLS_SALU  = 2'd3
    } t_pipe_class;

    // Action codes; any action with the upper bit set is a raw word.
    localparam logic [1:0] ACT_SINGLE = 2'd0;
    localparam logic [1:0] ACT_PAIR   = 2'd1;
    localparam logic [1:0] ACT_RAW    = 2'd2;

    // Delay ALU instruction in SOPP form: base 0xBF800000 with opcode 7 at bit 16.
    localparam logic [WORD_W-1:0] DELAY_ALU_WORD = 32'hBF87_0000;

    localparam logic [CODE_W-1:0] VALU_CODE_BASE  = 4'd1;
    localparam logic [CODE_W-1:0] VALU_SPAN       = 4'd4;
    localparam logic [CODE_W-1:0] TRANS_CODE_BASE = 4'd5;
    localparam logic [CODE_W-1:0] TRANS_SPAN      = 4'd3;
    localparam logic [CODE_W-1:0] SALU_CODE_BASE  = 4'd9;
    localparam logic [CODE_W-1:0] SALU_SPAN       = 4'd3;
    localparam logic [CODE_W-1:0] CODE_NONE       = 4'd0;

    typedef struct packed {
        t_pipe_class            cls;
        logic [SLOT_DIST_W-1:0] distance;
    } t_slot;

    typedef struct packed {
        logic advance;
        logic push;
    } t_cell_ctrl;

    function automatic logic [CODE_W-1:0] delay_code(t_pipe_class cls,
                                                     logic [SLOT_DIST_W-1:0] distance);
        logic [CODE_W-1:0] code;
        code = CODE_NONE;
        unique case (cls)
            CLS_VALU:  code = (distance < VALU_SPAN)  ? VALU_CODE_BASE + distance  : CODE_NONE;
            CLS_TRANS: code = (distance < TRANS_SPAN) ? TRANS_CODE_BASE + distance : CODE_NONE;
            CLS_SALU:  code = (distance < SALU_SPAN)  ? SALU_CODE_BASE + distance  : CODE_NONE;
            CLS_NONE:  code = CODE_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/adhi_if.sv =====
// Valid/ready channel interfaces for instruction items and emitted words.
// Depends on adhi_pkg for the word width.

interface adhi_item_if import adhi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic [1:0]        pipeline;

    modport source (output valid, output action, output first_word,
                    output second_word, output pipeline, input ready);
    modport sink   (input valid, input action, input first_word,
                    input second_word, input pipeline, output ready);
endinterface

interface adhi_word_if import adhi_pkg::*;;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              is_delay;
    logic              last;

    modport source (output valid, output out_word, output is_delay,
                    output last, input ready);
    modport sink   (input valid, input out_word, input is_delay,
                    input last, output ready);
endinterface

// ===== hdl/adhi_slot_cell.sv =====
// One producer slot: holds a pipeline class and distance, ages it and
// takes its neighbor's aged value on a push. Depends on adhi_pkg.

module adhi_slot_cell import adhi_pkg::*; #(
    parameter int unsigned EXPIRY_DISTANCE = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctrl          i_ctrl,
    input  t_slot               i_prev,
    output t_slot               o_aged,
    output t_slot               o_slot,
    output logic [CODE_W-1:0]   o_code
);

    localparam logic [SLOT_DIST_W-1:0] EXPIRY = SLOT_DIST_W'(EXPIRY_DISTANCE);

    t_slot r_slot;
    t_slot n_slot;
    logic [SLOT_DIST_W-1:0] w_dist;

    always_comb begin
        w_dist = (r_slot.cls != CLS_NONE) ? r_slot.distance + 1'b1 : r_slot.distance;
        o_aged.distance = w_dist;
        o_aged.cls      = (w_dist > EXPIRY) ? CLS_NONE : r_slot.cls;
        // take the neighbor's aged producer when a new one enters the chain
        n_slot = i_ctrl.push ? i_prev : o_aged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '{cls: CLS_NONE, distance: '0};
        end else if (i_ctrl.advance) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_code = delay_code(r_slot.cls, r_slot.distance);

endmodule

// ===== hdl/alu_delay_hazard_inserter.sv =====
// Top level of the ALU delay hazard inserter: producer slot chain plus
// a three-word emit buffer and output register. Depends on adhi_pkg,
// adhi_if and adhi_slot_cell.
//
//  channel   dir  payload                                       beats per item
//  i_item    in   action, first_word, second_word, pipeline     1
//  o_word    out  out_word, is_delay, last                      1 to 3
//
// An accepted item is checked against the slot chain in the cycle it is
// taken and its words enter the buffer; they leave one per cycle from the
// output register. A single-word item with no delay runs at one item per
// cycle; each extra beat (delay word, second word) holds i_item back.
// Reset (synchronous, i_rst_n low) empties the buffer and output register
// and clears both slots. A stalled o_word holds its beat and backs up i_item.

module alu_delay_hazard_inserter import adhi_pkg::*; #(
    parameter int unsigned EXPIRY_DISTANCE = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adhi_item_if.sink   i_item,
    adhi_word_if.source o_word
);

    t_cell_ctrl        w_ctrl;
    t_slot             w_prev [NUM_SLOTS];
    t_slot             w_aged [NUM_SLOTS];
    t_slot             w_slot [NUM_SLOTS];
    logic [CODE_W-1:0] w_code [NUM_SLOTS];
    logic [CODE_W-1:0] w_sel_code;

    logic              r_o_valid;
    logic [WORD_W-1:0] r_o_word;
    logic              r_o_delay;
    logic              r_o_last;

    logic [WORD_W-1:0] r_bw  [3];
    logic              r_bd  [3];
    logic [1:0]        r_cnt;
    logic [WORD_W-1:0] n_bw  [3];
    logic              n_bd  [3];
    logic [1:0]        n_cnt;

    logic w_adv;
    logic w_pop;
    logic w_fire;
    logic w_raw;
    logic w_pair;
    logic w_check;
    logic w_insert;
    logic [WORD_W-1:0] w_delay_word;

    assign w_raw   = i_item.action[1];
    assign w_pair  = (i_item.action == ACT_PAIR);
    assign w_check = !w_raw && (t_pipe_class'(i_item.pipeline) != CLS_NONE);

    assign w_adv   = !r_o_valid || o_word.ready;
    assign w_pop   = w_adv && (r_cnt != 2'd0);
    assign i_item.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && w_adv);
    assign w_fire  = i_item.valid && i_item.ready;

    assign w_ctrl.advance = w_fire;
    assign w_ctrl.push    = w_check;

    generate
        for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_slot
            if (k == 0) begin : g_head
                assign w_prev[k] = '{cls: t_pipe_class'(i_item.pipeline), distance: '0};
            end else begin : g_body
                assign w_prev[k] = w_aged[k-1];
            end
            adhi_slot_cell #(
                .EXPIRY_DISTANCE(EXPIRY_DISTANCE)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_prev  (w_prev[k]),
                .o_aged  (w_aged[k]),
                .o_slot  (w_slot[k]),
                .o_code  (w_code[k])
            );
        end
    endgenerate

    // first slot with a nonzero code wins; an older slot with no class reads as none
    assign w_sel_code = (w_code[0] != CODE_NONE) ? w_code[0] :
                        ((w_slot[1].cls != CLS_NONE) ? w_code[1] : CODE_NONE);
    assign w_insert     = w_check && (w_sel_code != CODE_NONE);
    assign w_delay_word = DELAY_ALU_WORD | WORD_W'(w_sel_code);

    always_comb begin
        n_bw  = r_bw;
        n_bd  = r_bd;
        n_cnt = r_cnt;
        if (w_fire) begin
            // load the new item's beats; delay word leads when one is due
            if (w_insert) begin
                n_bw[0] = w_delay_word;
                n_bw[1] = i_item.first_word;
                n_bw[2] = i_item.second_word;
                n_bd[0] = 1'b1;
            end else begin
                n_bw[0] = i_item.first_word;
                n_bw[1] = i_item.second_word;
                n_bw[2] = i_item.second_word;
                n_bd[0] = 1'b0;
            end
            n_bd[1] = 1'b0;
            n_bd[2] = 1'b0;
            n_cnt = 2'd1 + {1'b0, w_insert} + {1'b0, w_pair && !w_raw};
        end else if (w_pop) begin
            n_bw[0] = r_bw[1];
            n_bw[1] = r_bw[2];
            n_bd[0] = r_bd[1];
            n_bd[1] = r_bd[2];
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_adv) begin
                r_o_valid <= (r_cnt != 2'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bw <= n_bw;
        r_bd <= n_bd;
        if (w_adv) begin
            r_o_word  <= r_bw[0];
            r_o_delay <= r_bd[0];
            r_o_last  <= (r_cnt == 2'd1);
        end
    end

    assign o_word.valid    = r_o_valid;
    assign o_word.out_word = r_o_word;
    assign o_word.is_delay = r_o_delay;
    assign o_word.last     = r_o_last;

endmodule

// ===== tb/tb_alu_delay_hazard_inserter.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for alu_delay_hazard_inserter: drives instruction items,
// predicts the emitted and inserted delay words, and checks every output beat.
// Depends on adhi_pkg, adhi_if and the inserter RTL.

module tb_alu_delay_hazard_inserter;
    import adhi_pkg::*;

    localparam int unsigned EXPIRY      = 7;
    localparam logic [1:0]  ACT_UNDEF   = 2'd3;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              is_delay;
        logic              last;
    } t_emit;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    adhi_item_if item_if();
    adhi_word_if word_if();

    alu_delay_hazard_inserter #(.EXPIRY_DISTANCE(EXPIRY)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_word  (word_if)
    );

    always #5 i_clk = ~i_clk;

    // Producer tracking mirrored from the block, slot 0 the most recent.
    t_pipe_class            prod_cls[NUM_SLOTS];
    logic [SLOT_DIST_W-1:0] prod_dist[NUM_SLOTS];
    t_emit                  pending_words[$];

    int unsigned src_gap_pct;
    int unsigned sink_stall_pct;
    int unsigned err_count;
    int unsigned items_sent;
    int unsigned pairs_sent;
    int unsigned beats_seen;
    int unsigned delays_seen;

    function automatic logic [CODE_W-1:0] hazard_code(t_pipe_class cls,
                                                      logic [SLOT_DIST_W-1:0] distance);
        case (cls)
            CLS_VALU:  return (distance < VALU_SPAN)  ? VALU_CODE_BASE + distance  : CODE_NONE;
            CLS_TRANS: return (distance < TRANS_SPAN) ? TRANS_CODE_BASE + distance : CODE_NONE;
            CLS_SALU:  return (distance < SALU_SPAN)  ? SALU_CODE_BASE + distance  : CODE_NONE;
            default:   return CODE_NONE;
        endcase
    endfunction

    // Append one expected beat at the tail of the queue.
    function automatic void queue_beat(logic [WORD_W-1:0] word, logic dly, logic lst);
        t_emit beat;
        beat.word     = word;
        beat.is_delay = dly;
        beat.last     = lst;
        pending_words = {pending_words, beat};
    endfunction

    function automatic void predict_words(logic [1:0] action, logic [WORD_W-1:0] w0,
                                          logic [WORD_W-1:0] w1, t_pipe_class pipe);
        logic [CODE_W-1:0] code;
        t_pipe_class       producer;
        code     = CODE_NONE;
        producer = pipe;
        if (action == ACT_RAW || action == ACT_UNDEF) begin
            queue_beat(w0, 1'b0, 1'b1);
            producer = CLS_NONE;
        end else begin
            if (pipe != CLS_NONE) begin
                // first slot with a live hazard wins
                for (int s = 0; s < NUM_SLOTS; s++) begin
                    if (code == CODE_NONE) code = hazard_code(prod_cls[s], prod_dist[s]);
                end
                if (code != CODE_NONE)
                    queue_beat(DELAY_ALU_WORD | WORD_W'(code), 1'b1, 1'b0);
            end
            if (action == ACT_PAIR) begin
                queue_beat(w0, 1'b0, 1'b0);
                queue_beat(w1, 1'b0, 1'b1);
                pairs_sent++;
            end else begin
                queue_beat(w0, 1'b0, 1'b1);
            end
        end
        // age, retire, then shift in the new producer
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (prod_cls[s] != CLS_NONE) prod_dist[s] = prod_dist[s] + 1'b1;
            if (prod_dist[s] > EXPIRY) prod_cls[s] = CLS_NONE;
        end
        if (producer != CLS_NONE) begin
            prod_cls[1]  = prod_cls[0];
            prod_dist[1] = prod_dist[0];
            prod_cls[0]  = producer;
            prod_dist[0] = '0;
        end
    endfunction

    task automatic send_item(input logic [1:0] action, input logic [WORD_W-1:0] w0,
                             input logic [WORD_W-1:0] w1, input t_pipe_class pipe);
        while ($urandom_range(99) < src_gap_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid       <= 1'b1;
        item_if.action      <= action;
        item_if.first_word  <= w0;
        item_if.second_word <= w1;
        item_if.pipeline    <= pipe;
        // the item is committed once valid rises, so predict now
        predict_words(action, w0, w1, pipe);
        items_sent++;
        do @(posedge i_clk); while (!item_if.ready);
    endtask

    task automatic test_field_extremes();
        send_item(ACT_SINGLE, '0, ALL_ONES, CLS_NONE);
        send_item(ACT_PAIR, ALL_ONES, '0, CLS_SALU);
        send_item(ACT_PAIR, '0, ALL_ONES, CLS_VALU);
        send_item(ACT_RAW, ALL_ONES, ALL_ONES, CLS_TRANS);
        send_item(ACT_UNDEF, '0, ALL_ONES, CLS_SALU);
        send_item(ACT_SINGLE, ALL_ONES, '0, CLS_TRANS);
    endtask

    // Producer, then fillers up to the last distance that still needs a delay.
    task automatic test_hazard_window();
        t_pipe_class producers[3];
        int unsigned spans[3];
        producers = '{CLS_VALU, CLS_TRANS, CLS_SALU};
        spans     = '{VALU_SPAN, TRANS_SPAN, SALU_SPAN};
        for (int p = 0; p < 3; p++) begin
            send_item(ACT_SINGLE, $urandom, $urandom, producers[p]);
            repeat (spans[p] - 1) send_item(ACT_SINGLE, $urandom, $urandom, CLS_NONE);
            send_item(ACT_PAIR, $urandom, $urandom, CLS_VALU);
        end
    endtask

    task automatic test_consumer_none();
        send_item(ACT_SINGLE, $urandom, $urandom, CLS_SALU);
        send_item(ACT_PAIR, $urandom, $urandom, CLS_NONE);
    endtask

    // Mostly producer / filler / consumer runs with random content, some noise.
    task automatic test_random_mix(input int unsigned n_items);
        int unsigned first_item;
        first_item = items_sent;
        while (items_sent - first_item < n_items) begin
            if ($urandom_range(9) < 7) begin
                send_item($urandom_range(1) ? ACT_PAIR : ACT_SINGLE, $urandom, $urandom,
                          t_pipe_class'(2'($urandom_range(3, 1))));
                repeat ($urandom_range(8)) begin
                    case ($urandom_range(3))
                        0: send_item(ACT_SINGLE, $urandom, $urandom, CLS_NONE);
                        1: send_item(ACT_PAIR, $urandom, $urandom, CLS_NONE);
                        2: send_item(ACT_RAW, $urandom, $urandom,
                                     t_pipe_class'(2'($urandom_range(3))));
                        default: send_item(ACT_UNDEF, $urandom, $urandom,
                                           t_pipe_class'(2'($urandom_range(3))));
                    endcase
                end
                send_item($urandom_range(1) ? ACT_PAIR : ACT_SINGLE, $urandom, $urandom,
                          t_pipe_class'(2'($urandom_range(3, 1))));
            end else begin
                send_item(2'($urandom_range(3)), $urandom, $urandom,
                          t_pipe_class'(2'($urandom_range(3))));
            end
        end
    endtask

    initial begin : word_checker
        t_emit exp_word;
        word_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && word_if.valid && word_if.ready) begin
                beats_seen++;
                if (word_if.is_delay) delays_seen++;
                if (pending_words.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("beat %0d unexpected: word %h delay %b last %b", beats_seen,
                                 word_if.out_word, word_if.is_delay, word_if.last);
                end else begin
                    exp_word = pending_words.pop_front();
                    if (word_if.out_word !== exp_word.word ||
                        word_if.is_delay !== exp_word.is_delay ||
                        word_if.last !== exp_word.last) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("beat %0d: expected word %h delay %b last %b, got %h %b %b",
                                     beats_seen, exp_word.word, exp_word.is_delay,
                                     exp_word.last, word_if.out_word, word_if.is_delay,
                                     word_if.last);
                    end
                end
            end
            word_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned drain_cycles;
        item_if.valid       = 1'b0;
        item_if.action      = ACT_SINGLE;
        item_if.first_word  = '0;
        item_if.second_word = '0;
        item_if.pipeline    = CLS_NONE;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            prod_cls[s]  = CLS_NONE;
            prod_dist[s] = '0;
        end
        src_gap_pct    = 28;
        sink_stall_pct = 76;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_hazard_window();
        test_consumer_none();
        test_random_mix(60);
        src_gap_pct    = 76;
        sink_stall_pct = 28;
        test_random_mix(60);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_mix(60);
        item_if.valid <= 1'b0;

        drain_cycles = 0;
        while (pending_words.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_words.size() != 0) begin
            $display("%0d expected beats never arrived", pending_words.size());
            err_count += pending_words.size();
        end

        $display("Sent %0d items (%0d pairs), checked %0d beats of which %0d delay words.",
                 items_sent, pairs_sent, beats_seen, delays_seen);
        $display("Handshake mixes: sparse sender gaps with heavy stalls, the reverse, full rate.");
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
